/* rtl/text_display_port_controller_top_macros.svh */
// assertion helpers for the checker file
// each macro expects clk_i and rst_ni to be visible where it is used
`ifndef TEXT_DISPLAY_PORT_CONTROLLER_TOP_MACROS_SVH
`define TEXT_DISPLAY_PORT_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define TDPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tdpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared types, port codes and the color palette of the text display
// port controller.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  typedef enum logic [1:0] {
    KIND_PORT_READ  = 2'd0,
    KIND_PORT_WRITE = 2'd1,
    KIND_TICK       = 2'd2,
    KIND_QUERY      = 2'd3
  } tdpc_kind_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RD_CURSOR,
    OP_RD_PIT,
    OP_WR_CRTC,
    OP_WR_CURSOR,
    OP_WR_PTR,
    OP_WR_CELL,
    OP_FILL,
    OP_TICK,
    OP_QUERY
  } tdpc_op_e;

  typedef struct packed {
    tdpc_op_e    op;
    logic [15:0] value;
    logic [10:0] cell_index;
  } tdpc_cmd_t;

  localparam logic [15:0] PORT_CRTC_INDEX = 16'h0001;
  localparam logic [15:0] PORT_CRTC_DATA  = 16'h0002;
  localparam logic [15:0] PORT_PIT        = 16'h0003;
  localparam logic [15:0] PORT_VRAM_PTR   = 16'h0010;
  localparam logic [15:0] PORT_VRAM_DATA  = 16'h0011;
  localparam logic [15:0] PORT_VRAM_FILL  = 16'h0012;

  localparam logic [7:0] CRTC_CURSOR_HI = 8'h0E;
  localparam logic [7:0] CRTC_CURSOR_LO = 8'h0F;

  localparam logic [15:0] CELL_BLANK       = 16'h0720;
  localparam logic [15:0] PIT_PERIOD_RESET = 16'd50;

  // 16-color text palette, R<<16 | G<<8 | B
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

/* rtl/tdpc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tdpc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_front
// Accepts input transactions and decodes kind and port into a command
// for the queue.
// ----------------------------------------------------------------------------
module tdpc_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [15:0]          port_i,
  input  logic [15:0]          value_i,
  input  logic [10:0]          cell_index_i,
  input  logic                 q_full_i,
  input  logic                 init_busy_i,
  output logic                 push_o,
  output tdpc_pkg::tdpc_cmd_t  cmd_o
);

  tdpc_pkg::tdpc_op_e op;

  always_comb begin
    op = tdpc_pkg::OP_NOP;
    case (tdpc_pkg::tdpc_kind_e'(kind_i))
      tdpc_pkg::KIND_PORT_READ: begin
        if (port_i == tdpc_pkg::PORT_CRTC_DATA) begin
          op = tdpc_pkg::OP_RD_CURSOR;
        end else if (port_i == tdpc_pkg::PORT_PIT) begin
          op = tdpc_pkg::OP_RD_PIT;
        end
      end
      tdpc_pkg::KIND_PORT_WRITE: begin
        case (port_i)
          tdpc_pkg::PORT_CRTC_INDEX: op = tdpc_pkg::OP_WR_CRTC;
          tdpc_pkg::PORT_CRTC_DATA:  op = tdpc_pkg::OP_WR_CURSOR;
          tdpc_pkg::PORT_VRAM_PTR:   op = tdpc_pkg::OP_WR_PTR;
          tdpc_pkg::PORT_VRAM_DATA:  op = tdpc_pkg::OP_WR_CELL;
          tdpc_pkg::PORT_VRAM_FILL:  op = tdpc_pkg::OP_FILL;
          default:                   op = tdpc_pkg::OP_NOP;
        endcase
      end
      tdpc_pkg::KIND_TICK:  op = tdpc_pkg::OP_TICK;
      tdpc_pkg::KIND_QUERY: op = tdpc_pkg::OP_QUERY;
      default:              op = tdpc_pkg::OP_NOP;
    endcase
  end

  // hold off while the queue is full or the cell store is still being cleared
  assign in_stall_o = q_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign cmd_o.op         = op;
  assign cmd_o.value      = value_i;
  assign cmd_o.cell_index = cell_index_i;

endmodule

/* rtl/tdpc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_queue
// Two-entry command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module tdpc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tdpc_pkg::tdpc_cmd_t  cmd_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output tdpc_pkg::tdpc_cmd_t  cmd_o
);

  tdpc_pkg::tdpc_cmd_t entry_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

endmodule

/* rtl/tdpc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_back
// Executes decoded commands: CRTC and cursor registers, VRAM pointer and
// cell store, fill sweep, millisecond counter and the result register.
// ----------------------------------------------------------------------------
module tdpc_back #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_LINES   = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  tdpc_pkg::tdpc_cmd_t  cmd_i,
  output logic                 pop_o,
  output logic                 init_busy_o,
  input  logic                 cfg_valid_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          read_data_o,
  output logic [7:0]           char_code_o,
  output logic [23:0]          fg_rgb_o,
  output logic [23:0]          bg_rgb_o,
  output logic                 cursor_here_o
);

  localparam int          CELLS      = TEXT_COLUMNS * TEXT_LINES;
  localparam int          AW         = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [15:0] CELL_LIMIT = 16'(CELLS);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ
  } state_e;

  state_e         state_q, state_d;
  logic           init_q, init_d;
  logic [AW-1:0]  sweep_addr_q, sweep_addr_d;
  logic [15:0]    fill_val_q, fill_val_d;
  logic [15:0]    cursor_q, cursor_d;
  logic [7:0]     crtc_q, crtc_d;
  logic [15:0]    wptr_q, wptr_d;
  logic [15:0]    elapsed_q, elapsed_d;
  logic [15:0]    period_q, period_d;
  logic           pend_here_q, pend_here_d;
  logic           out_valid_q, out_valid_d;
  logic [15:0]    out_rd_q, out_rd_d;
  logic [7:0]     out_ch_q, out_ch_d;
  logic [23:0]    out_fg_q, out_fg_d;
  logic [23:0]    out_bg_q, out_bg_d;
  logic           out_here_q, out_here_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [15:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [15:0]    ram_rdata;
  logic [15:0]    cell_ext;
  logic           out_free;
  logic           pop;

  assign cell_ext  = 16'(cmd_i.cell_index);
  assign ram_raddr = cell_ext[AW-1:0];
  // result register can take a new transaction this cycle
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    sweep_addr_d = sweep_addr_q;
    fill_val_d   = fill_val_q;
    cursor_d     = cursor_q;
    crtc_d       = crtc_q;
    wptr_d       = wptr_q;
    elapsed_d    = elapsed_q;
    period_d     = period_q;
    pend_here_d  = pend_here_q;
    out_valid_d  = out_valid_q;
    out_rd_d     = out_rd_q;
    out_ch_d     = out_ch_q;
    out_fg_d     = out_fg_q;
    out_bg_d     = out_bg_q;
    out_here_d   = out_here_q;
    ram_we       = 1'b0;
    ram_waddr    = sweep_addr_q;
    ram_wdata    = fill_val_q;
    pop          = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      period_d = cfg_data_i;
    end

    case (state_q)
      ST_SWEEP: begin
        ram_we = 1'b1;
        if (sweep_addr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end else begin
          sweep_addr_d = sweep_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty_i && out_free) begin
          pop         = 1'b1;
          out_valid_d = 1'b1;
          out_rd_d    = 16'h0000;
          out_ch_d    = 8'h00;
          out_fg_d    = 24'h000000;
          out_bg_d    = 24'h000000;
          out_here_d  = 1'b0;
          case (cmd_i.op)
            tdpc_pkg::OP_RD_CURSOR: begin
              if (crtc_q == tdpc_pkg::CRTC_CURSOR_HI) begin
                out_rd_d = {8'h00, cursor_q[15:8]};
              end else if (crtc_q == tdpc_pkg::CRTC_CURSOR_LO) begin
                out_rd_d = {8'h00, cursor_q[7:0]};
              end
            end
            tdpc_pkg::OP_RD_PIT: begin
              if (elapsed_q >= period_q) begin
                out_rd_d  = 16'd1;
                elapsed_d = 16'd0;
              end
            end
            tdpc_pkg::OP_WR_CRTC: begin
              crtc_d = cmd_i.value[7:0];
            end
            tdpc_pkg::OP_WR_CURSOR: begin
              if (crtc_q == tdpc_pkg::CRTC_CURSOR_HI) begin
                cursor_d = {cmd_i.value[7:0], cursor_q[7:0]};
              end else if (crtc_q == tdpc_pkg::CRTC_CURSOR_LO) begin
                cursor_d = {cursor_q[15:8], cmd_i.value[7:0]};
              end
            end
            tdpc_pkg::OP_WR_PTR: begin
              wptr_d = cmd_i.value;
            end
            tdpc_pkg::OP_WR_CELL: begin
              // out-of-range pointer drops the write and stays put
              if (wptr_q < CELL_LIMIT) begin
                ram_we    = 1'b1;
                ram_waddr = wptr_q[AW-1:0];
                ram_wdata = cmd_i.value;
                wptr_d    = wptr_q + 16'd1;
              end
            end
            tdpc_pkg::OP_FILL: begin
              fill_val_d   = cmd_i.value;
              sweep_addr_d = '0;
              state_d      = ST_SWEEP;
            end
            tdpc_pkg::OP_TICK: begin
              if (elapsed_q != 16'hFFFF) begin
                elapsed_d = elapsed_q + 16'd1;
              end
            end
            tdpc_pkg::OP_QUERY: begin
              // in-range query waits in ST_READ for the registered cell read
              if (cell_ext < CELL_LIMIT) begin
                out_valid_d = 1'b0;
                pend_here_d = (cursor_q == cell_ext);
                state_d     = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_rd_d    = 16'h0000;
        out_ch_d    = ram_rdata[7:0];
        out_fg_d    = tdpc_pkg::palette_rgb(ram_rdata[11:8]);
        out_bg_d    = tdpc_pkg::palette_rgb(ram_rdata[15:12]);
        out_here_d  = pend_here_q;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      init_q       <= 1'b1;
      sweep_addr_q <= '0;
      fill_val_q   <= tdpc_pkg::CELL_BLANK;
      cursor_q     <= 16'h0000;
      crtc_q       <= 8'h00;
      wptr_q       <= 16'h0000;
      elapsed_q    <= 16'h0000;
      period_q     <= tdpc_pkg::PIT_PERIOD_RESET;
      pend_here_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_rd_q     <= 16'h0000;
      out_ch_q     <= 8'h00;
      out_fg_q     <= 24'h000000;
      out_bg_q     <= 24'h000000;
      out_here_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      sweep_addr_q <= sweep_addr_d;
      fill_val_q   <= fill_val_d;
      cursor_q     <= cursor_d;
      crtc_q       <= crtc_d;
      wptr_q       <= wptr_d;
      elapsed_q    <= elapsed_d;
      period_q     <= period_d;
      pend_here_q  <= pend_here_d;
      out_valid_q  <= out_valid_d;
      out_rd_q     <= out_rd_d;
      out_ch_q     <= out_ch_d;
      out_fg_q     <= out_fg_d;
      out_bg_q     <= out_bg_d;
      out_here_q   <= out_here_d;
    end
  end

  tdpc_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pop_o         = pop;
  assign init_busy_o   = init_q;
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rd_q;
  assign char_code_o   = out_ch_q;
  assign fg_rgb_o      = out_fg_q;
  assign bg_rgb_o      = out_bg_q;
  assign cursor_here_o = out_here_q;

endmodule

/* rtl/text_display_port_controller_top.sv */
`timescale 1ns / 1ps
// Accepted transactions pass the command queue, then the result register; an in-range
// cell query also passes ST_READ for the cell RAM read. Throughput: one transaction
// per cycle while out_stall_i is low and no query or fill sweep holds the back end.
// Reset: async active low; then a clearing sweep of TEXT_COLUMNS*TEXT_LINES cells
// (2000 by default) writes 0x0720 to every cell while in_stall_o stays high.
// ----------------------------------------------------------------------------
// text_display_port_controller_top
// Text-mode display controller behind I/O ports: front decode, command
// queue and execution back end with the cell store.
// ----------------------------------------------------------------------------
module text_display_port_controller_top #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_LINES   = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] port_i,
  input  logic [15:0] value_i,
  input  logic [10:0] cell_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic [7:0]  char_code_o,
  output logic [23:0] fg_rgb_o,
  output logic [23:0] bg_rgb_o,
  output logic        cursor_here_o
);

  tdpc_pkg::tdpc_cmd_t front_cmd;
  tdpc_pkg::tdpc_cmd_t queue_cmd;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  logic                init_busy;

  assign cfg_ready_o = 1'b1;

  tdpc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .port_i      (port_i),
    .value_i     (value_i),
    .cell_index_i(cell_index_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tdpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .cmd_o  (queue_cmd)
  );

  tdpc_back #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_LINES  (TEXT_LINES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .cmd_i        (queue_cmd),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .char_code_o  (char_code_o),
    .fg_rgb_o     (fg_rgb_o),
    .bg_rgb_o     (bg_rgb_o),
    .cursor_here_o(cursor_here_o)
  );

endmodule

/* rtl/tdpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_checker
// Port-level checks on the result channel of the text display controller.
// ----------------------------------------------------------------------------
`include "text_display_port_controller_top_macros.svh"

module tdpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] read_data_o,
  input logic [7:0]  char_code_o,
  input logic [23:0] fg_rgb_o,
  input logic [23:0] bg_rgb_o,
  input logic        cursor_here_o
);

  // a stalled transaction stays offered
  `TDPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // and keeps its payload
  `TDPC_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(read_data_o) && $stable(char_code_o) && $stable(fg_rgb_o) && $stable(bg_rgb_o) && $stable(cursor_here_o), "stalled result changed")

  // port reads return a cursor byte or the timer flag only
  `TDPC_ASSERT_NOW(a_rd_byte, out_valid_o, read_data_o[15:8] == 8'h00, "port read wider than a byte")

  // a port read result never carries cell query fields
  `TDPC_ASSERT_NOW(a_rd_excl, out_valid_o && (read_data_o != 16'h0000), (char_code_o == 8'h00) && (fg_rgb_o == 24'h000000) && (bg_rgb_o == 24'h000000) && !cursor_here_o, "read result mixed with query fields")

endmodule

bind text_display_port_controller_top tdpc_checker u_tdpc_checker (.*);
